// File: sv/qrs_pkg.sv
// shared types and constants for the quadratic root solver
`default_nettype none

package qrs_pkg;

    // coefficient and result widths
    localparam int COEF_W   = 16;
    localparam int OUT_W    = 32;
    localparam int OUT_FRAC = 16;

    // internal widths derived from the coefficient width
    localparam int PROD_W    = 2 * COEF_W;
    localparam int DISC_W    = 2 * COEF_W + 1;
    localparam int SQ_IN_W   = DISC_W + (DISC_W % 2);
    localparam int SQ_ROOT_W = SQ_IN_W / 2;
    localparam int MAG_W     = COEF_W + 2;
    localparam int NUM_W     = MAG_W + 1;
    localparam int DEN_W     = COEF_W + 1;
    localparam int DIVD_W    = MAG_W + OUT_FRAC;
    localparam int Q_W       = DIVD_W;

    // root kind codes
    localparam logic [1:0] KIND_DISTINCT = 2'd0;
    localparam logic [1:0] KIND_REPEATED = 2'd1;
    localparam logic [1:0] KIND_COMPLEX  = 2'd2;
    localparam logic [1:0] KIND_A_ZERO   = 2'd3;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } t_coef_in;

    typedef struct packed {
        logic [1:0]              root_kind;
        logic signed [OUT_W-1:0] first_value;
        logic signed [OUT_W-1:0] second_value;
        logic                    saturated;
    } t_root_out;

    // side data carried alongside the square root
    typedef struct packed {
        logic                   a_neg;
        logic                   a_zero;
        logic                   d_neg;
        logic                   d_zero;
        logic signed [COEF_W:0] nb;
        logic [COEF_W-1:0]      a_mag;
    } t_sq_side;

    // side data carried alongside the division
    typedef struct packed {
        logic [1:0] kind;
        logic       neg1;
        logic       neg2;
    } t_div_side;

endpackage

`default_nettype wire

// File: sv/qrs_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
`default_nettype none

module qrs_sqrt_pipe
    import qrs_pkg::*;
#(
    parameter int SB_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [SQ_IN_W-1:0]   i_radicand,
    input  logic [SB_W-1:0]      i_side,
    output logic                 o_valid,
    output logic [SQ_ROOT_W-1:0] o_root,
    output logic [SB_W-1:0]      o_side
);

    localparam int N     = SQ_ROOT_W;
    localparam int REM_W = SQ_ROOT_W + 3;

    logic                 r_v    [N];
    logic [SQ_IN_W-1:0]   r_x    [N];
    logic [REM_W-1:0]     r_rem  [N];
    logic [SQ_ROOT_W-1:0] r_root [N];
    logic [SB_W-1:0]      r_sd   [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic                 v_in;
        logic [SQ_IN_W-1:0]   x_in;
        logic [REM_W-1:0]     rem_in;
        logic [SQ_ROOT_W-1:0] root_in;
        logic [SB_W-1:0]      sd_in;
        logic [REM_W:0]       pend;
        logic [REM_W:0]       trial;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign x_in    = i_radicand;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sd_in   = i_side;
        end else begin : g_next
            assign v_in    = r_v[g-1];
            assign x_in    = r_x[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign sd_in   = r_sd[g-1];
        end

        // bring down two radicand bits and form the trial subtrahend
        assign pend  = {rem_in[REM_W-2:0], x_in[SQ_IN_W-1 -: 2]};
        assign trial = {{(REM_W + 1 - SQ_ROOT_W - 2){1'b0}}, root_in, 2'b01};

        // valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= v_in;
            end
        end

        // one root bit
        always_ff @(posedge i_clk) begin
            r_x[g]  <= x_in << 2;
            r_sd[g] <= sd_in;
            if (pend >= trial) begin
                r_rem[g]  <= REM_W'(pend - trial);
                r_root[g] <= {root_in[SQ_ROOT_W-2:0], 1'b1};
            end else begin
                r_rem[g]  <= pend[REM_W-1:0];
                r_root[g] <= {root_in[SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_sd[N-1];

endmodule

`default_nettype wire

// File: sv/qrs_div_pipe.sv
// pipelined restoring divider, two numerators over one divisor, one bit per stage
`default_nettype none

module qrs_div_pipe
    import qrs_pkg::*;
#(
    parameter int SB_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [MAG_W-1:0] i_num1,
    input  logic [MAG_W-1:0] i_num2,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_side,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quo1,
    output logic [Q_W-1:0]   o_quo2,
    output logic [SB_W-1:0]  o_side
);

    localparam int N = DIVD_W;

    logic              r_v   [N];
    logic [DIVD_W-1:0] r_x   [N][2];
    logic [DEN_W-1:0]  r_rem [N][2];
    logic [DEN_W-1:0]  r_den [N];
    logic [SB_W-1:0]   r_sd  [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic             v_in;
        logic [DEN_W-1:0] den_in;
        logic [SB_W-1:0]  sd_in;

        if (g == 0) begin : g_first
            assign v_in   = i_valid;
            assign den_in = i_den;
            assign sd_in  = i_side;
        end else begin : g_next
            assign v_in   = r_v[g-1];
            assign den_in = r_den[g-1];
            assign sd_in  = r_sd[g-1];
        end

        // valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[g] <= den_in;
            r_sd[g]  <= sd_in;
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DIVD_W-1:0] x_in;
            logic [DEN_W-1:0]  rem_in;
            logic [DEN_W:0]    t;

            if (g == 0) begin : g_first
                assign x_in   = (l == 0) ? {i_num1, {OUT_FRAC{1'b0}}}
                                         : {i_num2, {OUT_FRAC{1'b0}}};
                assign rem_in = '0;
            end else begin : g_next
                assign x_in   = r_x[g-1][l];
                assign rem_in = r_rem[g-1][l];
            end

            // shift in the next dividend bit and try a subtract
            assign t = {rem_in, x_in[DIVD_W-1]};

            always_ff @(posedge i_clk) begin
                if (t >= {1'b0, den_in}) begin
                    r_rem[g][l] <= DEN_W'(t - {1'b0, den_in});
                    r_x[g][l]   <= {x_in[DIVD_W-2:0], 1'b1};
                end else begin
                    r_rem[g][l] <= t[DEN_W-1:0];
                    r_x[g][l]   <= {x_in[DIVD_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quo1  = r_x[N-1][0];
    assign o_quo2  = r_x[N-1][1];
    assign o_side  = r_sd[N-1];

endmodule

`default_nettype wire

// File: sv/quadratic_root_solver_unit.sv
// quadratic root solver top level: discriminant, square root, division, saturation
// the result strobe follows the input, product, discriminant, square-root, numerator, divider and output registers
// throughput: one item per cycle; busy never rises, the result side cannot stall
// the depth is set by the 17-stage square root and the 34-stage divider
// synchronous active-low reset clears every valid bit; payload registers are not reset
`default_nettype none

module quadratic_root_solver_unit
    import qrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_coef_in  i_coef,
    output logic      o_valid,
    output t_root_out o_result
);

    // final sign and saturation: {sat, value}
    function automatic logic [OUT_W:0] fix_result(logic [Q_W-1:0] q, logic neg);
        logic [OUT_W:0] res;
        res = '0;
        if (q == '0) begin
            res = '0;
        end else if (!neg) begin
            if (q > Q_W'(33'h0_7FFF_FFFF)) begin
                res = {1'b1, 32'h7FFF_FFFF};
            end else begin
                res = {1'b0, q[OUT_W-1:0]};
            end
        end else begin
            if (q > Q_W'(33'h0_8000_0000)) begin
                res = {1'b1, 32'h8000_0000};
            end else begin
                res = {1'b0, OUT_W'(-q[OUT_W-1:0])};
            end
        end
        return res;
    endfunction

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input register
    logic     r_a_v;
    t_coef_in r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_coef;
        end
    end

    // products b*b and a*c
    logic                     r_b_v;
    logic signed [PROD_W-1:0] r_bb;
    logic signed [PROD_W-1:0] r_ac;
    t_sq_side                 r_b_side;
    t_sq_side                 b_side;

    always_comb begin
        b_side        = '0;
        b_side.a_neg  = r_in.coef_a[COEF_W-1];
        b_side.a_zero = (r_in.coef_a == '0);
        b_side.nb     = -$signed({r_in.coef_b[COEF_W-1], r_in.coef_b});
        b_side.a_mag  = r_in.coef_a[COEF_W-1] ? COEF_W'(-r_in.coef_a) : r_in.coef_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bb     <= PROD_W'(r_in.coef_b) * PROD_W'(r_in.coef_b);
        r_ac     <= PROD_W'(r_in.coef_a) * PROD_W'(r_in.coef_c);
        r_b_side <= b_side;
    end

    // discriminant sign and magnitude
    logic                     r_c_v;
    logic [SQ_IN_W-1:0]       r_rad;
    t_sq_side                 r_c_side;
    logic signed [DISC_W+1:0] disc;
    logic [DISC_W-1:0]        disc_mag;
    t_sq_side                 c_side;

    always_comb begin
        disc     = (DISC_W + 2)'(r_bb) - ((DISC_W + 2)'(r_ac) <<< 2);
        disc_mag = disc[DISC_W+1] ? DISC_W'(-disc) : DISC_W'(disc);
        c_side        = r_b_side;
        c_side.d_neg  = disc[DISC_W+1];
        c_side.d_zero = (disc == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad    <= SQ_IN_W'(disc_mag);
        r_c_side <= c_side;
    end

    // square root of the discriminant magnitude
    logic                 sq_v;
    logic [SQ_ROOT_W-1:0] sq_root;
    t_sq_side             sq_side;

    qrs_sqrt_pipe #(
        .SB_W($bits(t_sq_side))
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_c_v),
        .i_radicand (r_rad),
        .i_side     (r_c_side),
        .o_valid    (sq_v),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    // numerators, signs and divisor
    logic                    r_p_v;
    logic [MAG_W-1:0]        r_mag1;
    logic [MAG_W-1:0]        r_mag2;
    logic [DEN_W-1:0]        r_den;
    t_div_side               r_p_side;
    logic signed [NUM_W-1:0] nb_ext;
    logic signed [NUM_W-1:0] s_ext;
    logic signed [NUM_W-1:0] num1;
    logic signed [NUM_W-1:0] num2;
    t_div_side               p_side;

    always_comb begin
        nb_ext = NUM_W'(sq_side.nb);
        s_ext  = $signed(NUM_W'(sq_root));
        num1   = sq_side.d_neg ? nb_ext : nb_ext + s_ext;
        num2   = sq_side.d_neg ? s_ext : nb_ext - s_ext;
        p_side = '0;
        if (sq_side.a_zero) begin
            p_side.kind = KIND_A_ZERO;
        end else if (sq_side.d_zero) begin
            p_side.kind = KIND_REPEATED;
        end else if (sq_side.d_neg) begin
            p_side.kind = KIND_COMPLEX;
        end else begin
            p_side.kind = KIND_DISTINCT;
        end
        p_side.neg1 = num1[NUM_W-1] ^ sq_side.a_neg;
        p_side.neg2 = num2[NUM_W-1] ^ sq_side.a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else begin
            r_p_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag1   <= num1[NUM_W-1] ? MAG_W'(-num1) : MAG_W'(num1);
        r_mag2   <= num2[NUM_W-1] ? MAG_W'(-num2) : MAG_W'(num2);
        r_den    <= {sq_side.a_mag, 1'b0};
        r_p_side <= p_side;
    end

    // division by 2a
    logic           dv_v;
    logic [Q_W-1:0] quo1;
    logic [Q_W-1:0] quo2;
    t_div_side      dv_side;

    qrs_div_pipe #(
        .SB_W($bits(t_div_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_v),
        .i_num1  (r_mag1),
        .i_num2  (r_mag2),
        .i_den   (r_den),
        .i_side  (r_p_side),
        .o_valid (dv_v),
        .o_quo1  (quo1),
        .o_quo2  (quo2),
        .o_side  (dv_side)
    );

    // sign, saturation and output register
    logic      r_out_v;
    t_root_out r_out;
    t_root_out n_out;
    logic [OUT_W:0] fix1;
    logic [OUT_W:0] fix2;

    always_comb begin
        fix1  = fix_result(quo1, dv_side.neg1);
        fix2  = fix_result(quo2, dv_side.neg2);
        n_out = '0;
        n_out.root_kind = dv_side.kind;
        if (dv_side.kind != KIND_A_ZERO) begin
            n_out.first_value  = fix1[OUT_W-1:0];
            n_out.second_value = fix2[OUT_W-1:0];
            n_out.saturated    = fix1[OUT_W] | fix2[OUT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

`default_nettype wire
